// ===== rtl/core/afa_pkg.sv =====
// ----------------------------------------------------------------------------
// afa_pkg: shared types and constants of the aligned first-fit allocator
// Pool geometry, descriptor layout and sequencer state encoding.
// ----------------------------------------------------------------------------
package afa_pkg;

    localparam int POOL_FRAMES  = 8192;
    localparam int BUFFER_SLOTS = 64;
    localparam int WORD_BITS    = 32;

    localparam int FRAME_W  = $clog2(POOL_FRAMES);        // frame number
    localparam int CNT_W    = FRAME_W + 1;                // count up to pool size
    localparam int POS_W    = FRAME_W + 2;                // candidate plus length
    localparam int SLOT_W   = $clog2(BUFFER_SLOTS);       // slot index
    localparam int LINK_W   = SLOT_W + 1;                 // link, holds end mark
    localparam int WORDS    = POOL_FRAMES / WORD_BITS;
    localparam int WADDR_W  = $clog2(WORDS);
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int PAGE_SH  = 12;                         // 4096-byte pages

    localparam int KIND_W   = 1;
    localparam int PCNT_W   = 14;
    localparam int ALGN_W   = 14;
    localparam int FLAGS_W  = 8;
    localparam int OWNER_W  = 16;
    localparam int SID_W    = 7;
    localparam int GSLOT_W  = 6;
    localparam int ADDR_W   = 64;
    localparam int FFREE_W  = 14;
    localparam int IN_DW    = 64;
    localparam int OUT_DW   = 88;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic CFG_ENABLED = 1'b0;
    localparam logic CFG_BASE    = 1'b1;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [FLAGS_W-1:0] flags;
        logic [CNT_W-1:0]   len;
        logic [FRAME_W-1:0] start;
        logic [LINK_W-1:0]  next;
    } t_slot;

    typedef enum logic [10:0] {
        ST_CLR     = 11'b000_0000_0001,
        ST_IDLE    = 11'b000_0000_0010,
        ST_POP     = 11'b000_0000_0100,
        ST_FCHK    = 11'b000_0000_1000,
        ST_SCAN_RD = 11'b000_0001_0000,
        ST_SCAN_EV = 11'b000_0010_0000,
        ST_ALIGN   = 11'b000_0100_0000,
        ST_MARK_RD = 11'b000_1000_0000,
        ST_MARK_WR = 11'b001_0000_0000,
        ST_SLOT_WR = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } t_state;

endpackage

// ===== rtl/core/aligned_first_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// aligned_first_fit_page_allocator: bitmap page-frame allocator
// An allocate reads and checks each 32-frame bitmap word it scans, steps the
// candidate once per alignment step, then reads and writes each word it marks.
// A free reads and writes each word of the run. Rejected requests are answered
// without touching the bitmap; an allocate that finds no run pays for the whole scan.
// One request at a time; the bitmap memory port sets the pace.
// After reset a clearing pass zeroes all 256 bitmap words; no request is
// taken meanwhile (configuration writes are always taken).
// ----------------------------------------------------------------------------
module aligned_first_fit_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [afa_pkg::ADDR_W-1:0]    i_cfg_data,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: page_count[13:0], alignment[27:14], buffer_flags[35:28],
    //        owner_id[51:36], slot_id[58:52], zero pad[63:59]
    input  logic [afa_pkg::IN_DW-1:0]     i_s_tdata,
    // tuser: kind
    input  logic                          i_s_tuser,
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: granted_slot[5:0], physical_address[69:6], frames_free[83:70],
    //        zero pad[87:84]
    output logic [afa_pkg::OUT_DW-1:0]    o_m_tdata,
    // tuser: status
    output logic                          o_m_tuser
);
    import afa_pkg::*;

    // request fields
    logic [PCNT_W-1:0]  in_count;
    logic [ALGN_W-1:0]  in_align;
    logic [FLAGS_W-1:0] in_flags;
    logic [OWNER_W-1:0] in_owner;
    logic [SID_W-1:0]   in_sid;

    assign in_count = i_s_tdata[13:0];
    assign in_align = i_s_tdata[27:14];
    assign in_flags = i_s_tdata[35:28];
    assign in_owner = i_s_tdata[51:36];
    assign in_sid   = i_s_tdata[58:52];

    t_state              r_state;
    logic                r_enabled;
    logic [ADDR_W-1:0]   r_base;
    logic                r_kind;
    logic [CNT_W-1:0]    r_count;
    logic [POS_W-1:0]    r_align;
    logic [FLAGS_W-1:0]  r_flags;
    logic [OWNER_W-1:0]  r_owner;
    logic [SID_W-1:0]    r_sid;
    logic [LINK_W-1:0]   r_head;
    logic [CNT_W-1:0]    r_free_cnt;
    logic [SLOT_W-1:0]   r_slot;
    logic [POS_W-1:0]    r_c;       // aligned candidate start
    logic [POS_W-1:0]    r_p;       // scan / mark position
    logic [POS_W-1:0]    r_u;       // used frame that broke the window
    logic [POS_W-1:0]    r_lo;
    logic [POS_W-1:0]    r_hi;      // exclusive end of the run
    logic                r_set;     // mark sets bits, else clears
    logic                r_ok;
    logic [CNT_W-1:0]    r_len;
    logic [WADDR_W-1:0]  r_clr;
    logic [BUFFER_SLOTS-1:0] r_slot_vld;

    logic                r_out_valid;
    logic                r_status;
    logic [GSLOT_W-1:0]  r_gslot;
    logic [ADDR_W-1:0]   r_addr;
    logic [FFREE_W-1:0]  r_ffree;

    // memories
    logic [WORD_BITS-1:0] bm_mem [WORDS];
    logic [WORD_BITS-1:0] r_bm_q;
    t_slot                slot_mem [BUFFER_SLOTS];
    t_slot                r_slot_q;
    logic                 r_slot_vq;

    logic                 bm_we;
    logic [WADDR_W-1:0]   bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic [WADDR_W-1:0]   bm_raddr;
    logic                 sl_we;
    logic [SLOT_W-1:0]    sl_waddr;
    t_slot                sl_wdata;
    logic [SLOT_W-1:0]    sl_raddr;

    // shared window / mask unit
    logic [POS_W-1:0]     win_end;
    logic [POS_W-1:0]     mask_lo;
    logic [POS_W-1:0]     mask_hi;
    logic [POS_W-1:0]     word_base;
    logic [POS_W-1:0]     word_next;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] used;
    logic [BIT_W-1:0]     first_used;
    logic [POS_W-1:0]     c_step;
    logic [POS_W-1:0]     bit_pos;
    logic                 alloc_ok;

    assign win_end   = r_c + POS_W'(r_count);
    assign c_step    = r_c + r_align;
    assign word_base = {r_p[POS_W-1:BIT_W], BIT_W'(0)};
    assign word_next = word_base + POS_W'(WORD_BITS);
    assign alloc_ok  = r_ok && (r_kind == KIND_ALLOC);

    always_comb begin
        if (r_state == ST_SCAN_EV) begin
            mask_lo = r_p;
            mask_hi = win_end;
        end else begin
            mask_lo = r_lo;
            mask_hi = r_hi;
        end
        for (int k = 0; k < WORD_BITS; k++) begin
            bit_pos = word_base + POS_W'(k);
            mask[k] = (bit_pos >= mask_lo) && (bit_pos < mask_hi);
        end
    end

    assign used = r_bm_q & mask;

    always_comb begin
        first_used = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (used[k]) begin
                first_used = BIT_W'(k);
            end
        end
    end

    // memory port control
    assign bm_raddr = r_p[FRAME_W-1:BIT_W];
    assign sl_raddr = (i_s_tuser == KIND_FREE) ? in_sid[SLOT_W-1:0] : r_head[SLOT_W-1:0];

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = r_p[FRAME_W-1:BIT_W];
        bm_wdata = r_set ? (r_bm_q | mask) : (r_bm_q & ~mask);
        if (r_state == ST_CLR) begin
            bm_we    = 1'b1;
            bm_waddr = r_clr;
            bm_wdata = '0;
        end else if (r_state == ST_MARK_WR) begin
            bm_we = 1'b1;
        end
    end

    always_comb begin
        sl_we    = (r_state == ST_SLOT_WR);
        sl_waddr = (r_kind == KIND_FREE) ? r_sid[SLOT_W-1:0] : r_slot;
        sl_wdata = '0;
        sl_wdata.next = r_head;
        if (alloc_ok) begin
            sl_wdata.owner = r_owner;
            sl_wdata.flags = r_flags;
            sl_wdata.len   = r_count;
            sl_wdata.start = r_c[FRAME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        r_bm_q <= bm_mem[bm_raddr];
        if (sl_we) begin
            slot_mem[sl_waddr] <= sl_wdata;
        end
        r_slot_q  <= slot_mem[sl_raddr];
        r_slot_vq <= r_slot_vld[sl_raddr];
    end

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_status;
    assign o_m_tdata   = {4'b0, r_ffree, r_addr, r_gslot};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_enabled   <= 1'b0;
            r_base      <= '0;
            r_head      <= '0;
            r_free_cnt  <= CNT_W'(POOL_FRAMES);
            r_slot_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration: taken at any time, expected only while idle
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ENABLED) begin
                    r_enabled <= i_cfg_data[0];
                end else begin
                    r_base <= i_cfg_data;
                end
            end

            // drop the sent response; the output state reloads it itself
            if (r_out_valid && i_m_tready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == WADDR_W'(WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind  <= i_s_tuser;
                        r_count <= CNT_W'(in_count);
                        r_align <= (in_align == '0) ? POS_W'(1) : POS_W'(in_align);
                        r_flags <= in_flags;
                        r_owner <= in_owner;
                        r_sid   <= in_sid;
                        r_ok    <= 1'b0;
                        if (!r_enabled) begin
                            r_state <= ST_OUT;
                        end else if (i_s_tuser == KIND_ALLOC) begin
                            if (in_count == '0 || in_count > PCNT_W'(POOL_FRAMES) ||
                                r_head >= LINK_W'(BUFFER_SLOTS)) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_POP;
                            end
                        end else if (in_sid >= SID_W'(BUFFER_SLOTS)) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_FCHK;
                        end
                    end
                end
                ST_POP: begin
                    // pop the head descriptor; an untouched one links to the next
                    r_slot <= r_head[SLOT_W-1:0];
                    r_head <= r_slot_vq ? r_slot_q.next : (r_head + 1'b1);
                    r_c    <= '0;
                    r_p    <= '0;
                    r_state <= ST_SCAN_RD;
                end
                ST_FCHK: begin
                    if (!r_slot_vq || r_slot_q.len == '0) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ok    <= 1'b1;
                        r_set   <= 1'b0;
                        r_len   <= r_slot_q.len;
                        r_lo    <= POS_W'(r_slot_q.start);
                        r_p     <= POS_W'(r_slot_q.start);
                        r_hi    <= POS_W'(r_slot_q.start) + POS_W'(r_slot_q.len);
                        r_state <= ST_MARK_RD;
                    end
                end
                ST_SCAN_RD: begin
                    if (win_end > POS_W'(POOL_FRAMES)) begin
                        r_state <= ST_SLOT_WR;     // no run: push slot back
                    end else if (r_p >= win_end) begin
                        r_ok    <= 1'b1;
                        r_set   <= 1'b1;
                        r_lo    <= r_c;
                        r_hi    <= win_end;
                        r_p     <= r_c;
                        r_state <= ST_MARK_RD;
                    end else begin
                        r_state <= ST_SCAN_EV;
                    end
                end
                ST_SCAN_EV: begin
                    if (used == '0) begin
                        r_p     <= word_next;
                        r_state <= ST_SCAN_RD;
                    end else begin
                        r_u     <= word_base + POS_W'(first_used);
                        r_state <= ST_ALIGN;
                    end
                end
                ST_ALIGN: begin
                    // advance the candidate past the used frame
                    r_c <= c_step;
                    if (c_step > r_u) begin
                        r_p     <= c_step;
                        r_state <= ST_SCAN_RD;
                    end
                end
                ST_MARK_RD: begin
                    r_state <= ST_MARK_WR;
                end
                ST_MARK_WR: begin
                    if (word_next >= r_hi) begin
                        r_state <= ST_SLOT_WR;
                    end else begin
                        r_p     <= word_next;
                        r_state <= ST_MARK_RD;
                    end
                end
                ST_SLOT_WR: begin
                    r_slot_vld[sl_waddr] <= 1'b1;
                    if (alloc_ok) begin
                        r_free_cnt <= r_free_cnt - r_count;
                    end else begin
                        r_head <= LINK_W'(sl_waddr);
                        if (r_ok) begin
                            r_free_cnt <= r_free_cnt + r_len;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_status    <= !r_ok;
                        r_gslot     <= alloc_ok ? GSLOT_W'(r_slot) : '0;
                        r_addr      <= alloc_ok ?
                                       (r_base + (ADDR_W'(r_c[FRAME_W-1:0]) << PAGE_SH)) : '0;
                        r_ffree     <= FFREE_W'(r_free_cnt);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
